// ===== src/rsd_pkg.sv =====
// Shared types and constants for the running standard deviation unit.
// Holds field widths, register indexes, reset values and the command and
// status structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_MEAN_FRACTION_BITS = 16;
  localparam int DEF_COUNT_BITS         = 12;

  // Field widths of the streaming and configuration ports.
  localparam int SAMPLE_W   = 16;
  localparam int MARGIN_W   = 15;
  localparam int SCOUNT_W   = 12;
  localparam int ACNT_W     = 12;
  localparam int DEV_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;
  localparam int M_TUSER_W  = 2;

  // Fraction bits of the deviation output; the radicand carries twice as many.
  localparam int DEV_FRAC_BITS = 8;
  localparam int RAD_FRAC_BITS = 2 * DEV_FRAC_BITS;

  // Accumulator, root and iteration counter widths.
  localparam int SUM_W  = 64;
  localparam int ROOT_W = SUM_W / 2;
  localparam int ITER_W = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd2;

  // Configuration reset values.
  localparam logic signed [SAMPLE_W-1:0] RST_REFERENCE = 16'sd1024;
  localparam logic [MARGIN_W-1:0]        RST_MARGIN    = 15'd31;
  localparam logic [SCOUNT_W-1:0]        RST_COUNT     = 12'd50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] reference_level;
    logic [MARGIN_W-1:0]        reject_margin;
    logic [SCOUNT_W-1:0]        sample_count;
  } cfg_t;

  // Single-bit commands from the controller to the datapath.
  typedef struct packed {
    logic load_sample;
    logic set_reject;
    logic set_accept;
    logic set_finish;
    logic div_load_mean;
    logic div_load_var;
    logic div_step;
    logic mean_update;
    logic mul_load;
    logic mul_step;
    logic acc_update;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic finish;
  } status_t;

endpackage

`default_nettype wire

// ===== src/rsd_div.sv =====
// Restoring serial divider, one quotient bit per cycle while step_i is high.
// Shared by the mean update and the final variance division; uses rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsd_div
  import rsd_pkg::*;
#(
  parameter int DEN_W = DEF_COUNT_BITS
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic      [SUM_W-1:0] quotient_o
);

  logic [SUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q[DEN_W-1:0], quo_q[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (step_i) begin
      if (trial[DEN_W+1]) begin
        rem_q <= shifted;
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end else begin
        rem_q <= trial[DEN_W:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== src/rsd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle while step_i is high.
// Produces floor(sqrt(radicand)) after ROOT_W steps; uses rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsd_sqrt
  import rsd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic              step_i,
  input  wire logic [SUM_W-1:0]  radicand_i,
  output logic      [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 2;

  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W:0]    rem_shift;
  logic [REM_W+1:0]  trial;

  // Append the next two radicand bits and test against 4*root + 1.
  assign rem_shift = {rem_q[REM_W-2:0], rad_q[SUM_W-1 -: 2]};
  assign trial     = {1'b0, rem_shift} - {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q <= {rad_q[SUM_W-3:0], 2'b00};
      if (trial[REM_W+1]) begin
        rem_q  <= rem_shift[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end else begin
        rem_q  <= trial[REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== src/rsd_datapath.sv =====
// Datapath of the running standard deviation unit: sample check, Welford
// mean and sum registers, serial multiplier, result and output registers.
// Instantiates rsd_div and rsd_sqrt; uses rsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsd_datapath
  import rsd_pkg::*;
#(
  parameter int MEAN_FRACTION_BITS = DEF_MEAN_FRACTION_BITS,
  parameter int COUNT_BITS         = DEF_COUNT_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfg_t                       cfg_i,
  input  wire cmd_t                       cmd_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output status_t                         status_o,
  output logic                            accepted_o,
  output logic [ACNT_W-1:0]               accepted_count_o,
  output logic                            finished_o,
  output logic [DEV_W-1:0]                deviation_o
);

  localparam int F      = MEAN_FRACTION_BITS;
  localparam int MW     = SAMPLE_W + F;
  localparam int PW     = 2 * MW;
  localparam int TERM_W = PW - F;
  localparam int SHL    = (F <= RAD_FRAC_BITS) ? RAD_FRAC_BITS - F : 0;
  localparam int SHR    = (F > RAD_FRAC_BITS) ? F - RAD_FRAC_BITS : 0;
  localparam int TGT_W  = 17;
  localparam logic [TGT_W-1:0] CMAX = TGT_W'((1 << COUNT_BITS) - 1);

  // Welford state.
  logic [COUNT_BITS-1:0]  taken_q, taken_d;
  logic signed [MW-1:0]   mean_q, mean_d;
  logic [SUM_W-1:0]       sum_q, sum_d;

  // Per-item working registers.
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       neg_q;
  logic [MW-1:0]              mag_a_q;
  logic [PW-1:0]              acc_q;

  // Pending result and output registers.
  logic              res_accepted_q, res_finished_q;
  logic [ACNT_W-1:0] res_count_q;
  logic [DEV_W-1:0]  res_dev_q;
  logic              out_accepted_q, out_finished_q;
  logic [ACNT_W-1:0] out_count_q;
  logic [DEV_W-1:0]  out_dev_q;

  logic [SAMPLE_W:0]     dist_raw, dist_abs;
  logic [MW-1:0]         x;
  logic [MW:0]           diff, diff_neg;
  logic [MW-1:0]         mag;
  logic [COUNT_BITS-1:0] n;
  logic [SCOUNT_W-1:0]   tgt_raw;
  logic [TGT_W-1:0]      tgt;
  logic [SUM_W-1:0]      dividend;
  logic [COUNT_BITS-1:0] divisor;
  logic [SUM_W-1:0]      quo;
  logic [MW:0]           q_ext, q_signed, mean_sum;
  logic [MW:0]           hi_sum;
  logic [TERM_W-1:0]     term;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_sat;
  logic [2*SUM_W-1:0]    wide;
  logic [SUM_W-1:0]      rescaled;
  logic [ROOT_W-1:0]     root;
  logic [DEV_W-1:0]      dev;

  // Outlier check: distance of the sample from the reference level.
  assign dist_raw = {sample_q[SAMPLE_W-1], sample_q}
                  - {cfg_i.reference_level[SAMPLE_W-1], cfg_i.reference_level};
  assign dist_abs = dist_raw[SAMPLE_W] ? (SAMPLE_W+1)'(0) - dist_raw : dist_raw;
  assign status_o.reject = dist_abs > {2'b00, cfg_i.reject_margin};

  // Target count: zero means one, and it cannot exceed the counter range.
  assign n       = taken_q + COUNT_BITS'(1);
  assign tgt_raw = (cfg_i.sample_count == '0) ? SCOUNT_W'(1) : cfg_i.sample_count;
  assign tgt     = (TGT_W'(tgt_raw) > CMAX) ? CMAX : TGT_W'(tgt_raw);
  assign status_o.finish = TGT_W'(n) >= tgt;

  // Scaled sample minus current mean, split into sign and magnitude.
  // Before the mean update this is the old deviation, after it the new one.
  assign x        = {sample_q, {F{1'b0}}};
  assign diff     = {x[MW-1], x} - {mean_q[MW-1], mean_q};
  assign diff_neg = (MW+1)'(0) - diff;
  assign mag      = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];

  // Shared divider: deviation over count, or squared sum over count.
  assign dividend = cmd_i.div_load_mean ? {mag, {(SUM_W-MW){1'b0}}} : sum_q;
  assign divisor  = cmd_i.div_load_mean ? n : taken_q;

  rsd_div #(
    .DEN_W (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load_mean | cmd_i.div_load_var),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quo)
  );

  // Mean update with the quotient truncated toward zero.
  assign q_ext    = {1'b0, quo[MW-1:0]};
  assign q_signed = neg_q ? (MW+1)'(0) - q_ext : q_ext;
  assign mean_sum = {mean_q[MW-1], mean_q} + q_signed;

  // Shift-add multiplier step: add the multiplicand into the upper half.
  assign hi_sum = {1'b0, acc_q[PW-1:MW]} + (acc_q[0] ? {1'b0, mag_a_q} : (MW+1)'(0));

  // Product term added to the squared sum with saturation.
  assign term    = acc_q[PW-1:F];
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(term);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // Variance rescaled to the radicand fraction width, saturating on overflow.
  assign wide     = {{SUM_W{1'b0}}, quo} << SHL;
  assign rescaled = (|wide[2*SUM_W-1:SUM_W]) ? '1 : (wide[SUM_W-1:0] >> SHR);

  rsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .load_i     (cmd_i.sqrt_load),
    .step_i     (cmd_i.sqrt_step),
    .radicand_i (rescaled),
    .root_o     (root)
  );

  assign dev = (|root[ROOT_W-1:DEV_W]) ? '1 : root[DEV_W-1:0];

  // Next state of the Welford accumulators.
  always_comb begin
    taken_d = taken_q;
    mean_d  = mean_q;
    sum_d   = sum_q;
    if (cmd_i.set_finish) begin
      taken_d = '0;
      mean_d  = '0;
      sum_d   = '0;
    end else begin
      if (cmd_i.acc_update) begin
        taken_d = n;
        sum_d   = sum_sat;
      end
      if (cmd_i.mean_update) begin
        mean_d = mean_sum[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
      mean_q  <= '0;
      sum_q   <= '0;
    end else begin
      taken_q <= taken_d;
      mean_q  <= mean_d;
      sum_q   <= sum_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_i;
    end
    if (cmd_i.div_load_mean) begin
      neg_q   <= diff[MW];
      mag_a_q <= mag;
    end
    if (cmd_i.mul_load) begin
      acc_q <= {{MW{1'b0}}, mag};
    end else if (cmd_i.mul_step) begin
      acc_q <= {hi_sum, acc_q[MW-1:1]};
    end
  end

  // Pending result, then the output register once the receiver is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_reject) begin
      res_accepted_q <= 1'b0;
      res_count_q    <= ACNT_W'(taken_q);
      res_finished_q <= 1'b0;
      res_dev_q      <= '0;
    end else if (cmd_i.set_accept) begin
      res_accepted_q <= 1'b1;
      res_count_q    <= ACNT_W'(n);
      res_finished_q <= 1'b0;
      res_dev_q      <= '0;
    end else if (cmd_i.set_finish) begin
      res_accepted_q <= 1'b1;
      res_count_q    <= ACNT_W'(taken_q);
      res_finished_q <= 1'b1;
      res_dev_q      <= dev;
    end
    if (cmd_i.out_load) begin
      out_accepted_q <= res_accepted_q;
      out_count_q    <= res_count_q;
      out_finished_q <= res_finished_q;
      out_dev_q      <= res_dev_q;
    end
  end

  assign accepted_o       = out_accepted_q;
  assign accepted_count_o = out_count_q;
  assign finished_o       = out_finished_q;
  assign deviation_o      = out_dev_q;

endmodule

`default_nettype wire

// ===== src/rsd_ctrl.sv =====
// Controller of the running standard deviation unit: sequences the
// check, divide, multiply, accumulate and square root steps of one beat.
// Drives the command struct of rsd_pkg and owns the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module rsd_ctrl
  import rsd_pkg::*;
#(
  parameter int MEAN_FRACTION_BITS = DEF_MEAN_FRACTION_BITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [ITER_W-1:0] ITER_MEAN = ITER_W'(SAMPLE_W + MEAN_FRACTION_BITS);
  localparam logic [ITER_W-1:0] ITER_VAR  = ITER_W'(SUM_W);
  localparam logic [ITER_W-1:0] ITER_SQRT = ITER_W'(ROOT_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_MDIV   = 4'd2;
  localparam logic [3:0] ST_MEAN   = 4'd3;
  localparam logic [3:0] ST_MLOAD  = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_ACC    = 4'd6;
  localparam logic [3:0] ST_VLOAD  = 4'd7;
  localparam logic [3:0] ST_VDIV   = 4'd8;
  localparam logic [3:0] ST_SQLOAD = 4'd9;
  localparam logic [3:0] ST_SQRT   = 4'd10;
  localparam logic [3:0] ST_FIN    = 4'd11;
  localparam logic [3:0] ST_OUT    = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // Next state, iteration count and commands.
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_sample = 1'b1;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.reject) begin
          cmd_o.set_reject = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.div_load_mean = 1'b1;
          iter_d  = ITER_MEAN;
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        cmd_o.div_step = 1'b1;
        iter_d = iter_q - ITER_LAST;
        if (iter_q == ITER_LAST) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: begin
        cmd_o.mean_update = 1'b1;
        state_d = ST_MLOAD;
      end
      ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        iter_d  = ITER_MEAN;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        iter_d = iter_q - ITER_LAST;
        if (iter_q == ITER_LAST) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_update = 1'b1;
        if (status_i.finish) begin
          state_d = ST_VLOAD;
        end else begin
          cmd_o.set_accept = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_VLOAD: begin
        cmd_o.div_load_var = 1'b1;
        iter_d  = ITER_VAR;
        state_d = ST_VDIV;
      end
      ST_VDIV: begin
        cmd_o.div_step = 1'b1;
        iter_d = iter_q - ITER_LAST;
        if (iter_q == ITER_LAST) begin
          state_d = ST_SQLOAD;
        end
      end
      ST_SQLOAD: begin
        cmd_o.sqrt_load = 1'b1;
        iter_d  = ITER_SQRT;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        iter_d = iter_q - ITER_LAST;
        if (iter_q == ITER_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.set_finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output register stays full until the receiver takes the beat.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/running_std_dev_outlier_reject_unit.sv =====
// Running standard deviation with outlier rejection (Welford's method).
//
// Input beats on the s_axis channel carry one signed 16-bit sample. Samples
// further than reject_margin from reference_level are rejected and not
// counted; the others update a running mean and squared sum. Every input
// beat yields exactly one output beat on m_axis: accepted flag, count so
// far, finished flag and, on the beat that completes sample_count accepted
// samples, the deviation sqrt(sum / count) with 8 fraction bits, after which
// the accumulators clear. Configuration writes use the cfg channel, which is
// always ready, and should be made only while the block is idle.
// One sample is processed at a time. A rejected sample passes through the
// check and output states before the next ready; an accepted one also runs
// the bit-serial mean division, the mean update, the bit-serial multiplier
// and the accumulate step; a finishing sample adds the 64-step division and
// the 32-step square root. A finished result waits in the output register
// while the next sample is accepted; the block stalls only if a second
// result is ready before the first is taken. Reset clears the accumulators
// and loads the register defaults: reference 1024, margin 31, count 50.
`timescale 1ns / 1ps
`default_nettype none

module running_std_dev_outlier_reject_unit
  import rsd_pkg::*;
#(
  parameter int MEAN_FRACTION_BITS = DEF_MEAN_FRACTION_BITS,
  parameter int COUNT_BITS         = DEF_COUNT_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input stream.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  // Output stream.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,   // [11:0] accepted_count,
                                                     // [35:12] deviation, [39:36] zero
  output logic [M_TUSER_W-1:0]       m_axis_tuser,   // [0] accepted, [1] finished
  // Configuration writes.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q, cfg_d;
  cmd_t              cmd;
  status_t           status;
  logic              accepted, finished;
  logic [ACNT_W-1:0] accepted_count;
  logic [DEV_W-1:0]  deviation;

  // Configuration registers; indexes beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REFERENCE: cfg_d.reference_level = cfg_data_i;
        REG_MARGIN:    cfg_d.reject_margin   = cfg_data_i[MARGIN_W-1:0];
        REG_COUNT:     cfg_d.sample_count    = cfg_data_i[SCOUNT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reference_level <= RST_REFERENCE;
      cfg_q.reject_margin   <= RST_MARGIN;
      cfg_q.sample_count    <= RST_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer.
  rsd_ctrl #(
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic and result registers.
  rsd_datapath #(
    .MEAN_FRACTION_BITS (MEAN_FRACTION_BITS),
    .COUNT_BITS         (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sample_i         (s_axis_tdata[SAMPLE_W-1:0]),
    .status_o         (status),
    .accepted_o       (accepted),
    .accepted_count_o (accepted_count),
    .finished_o       (finished),
    .deviation_o      (deviation)
  );

  // Output beat packing.
  assign m_axis_tdata = {{(M_TDATA_W-ACNT_W-DEV_W){1'b0}}, deviation, accepted_count};
  assign m_axis_tuser = {finished, accepted};

  // One sample at a time: the block is busy right after taking a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample was still in work");

  // A finished measurement always counts its last sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("finished beat without an accepted sample");

  // The deviation field is zero unless the beat finishes a measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata[ACNT_W +: DEV_W] == '0))
    else $error("nonzero deviation on an unfinished beat");

endmodule

`default_nettype wire
